// ===== rtl/ipv4dq_pkg.sv =====
// Shared types, status codes and field checks for the IPv4 dotted-quad parser.
package ipv4dq_pkg;

  localparam int unsigned DefMinLen = 7;
  localparam int unsigned DefMaxLen = 15;

  typedef enum logic [3:0] {
    ST_OK           = 4'd0,
    ST_SHORT        = 4'd1,
    ST_LONG         = 4'd2,
    ST_MANY_FIELDS  = 4'd3,
    ST_EMPTY        = 4'd4,
    ST_LEADING_ZERO = 4'd5,
    ST_BIG          = 4'd6,
    ST_MANY_DIGITS  = 4'd7,
    ST_BAD_CHAR     = 4'd8,
    ST_FEW_FIELDS   = 4'd9
  } status_e;

  localparam logic [7:0] ChDot  = 8'h2e;
  localparam logic [7:0] ChZero = 8'h30;
  localparam logic [7:0] ChNine = 8'h39;

  typedef struct packed {
    logic [31:0] address;
    status_e     status;
  } result_t;

  function automatic status_e close_check(input logic [9:0] accum, input logic [2:0] dcnt);
    status_e st;
    st = ST_OK;
    case (dcnt)
      3'd0: st = ST_EMPTY;
      3'd1: st = ST_OK;
      3'd2: if (accum < 10'd10) st = ST_LEADING_ZERO;
      3'd3: begin
        if (accum < 10'd100) st = ST_LEADING_ZERO;
        else if (accum > 10'd255) st = ST_BIG;
      end
      default: st = ST_MANY_DIGITS;
    endcase
    return st;
  endfunction

endpackage

// ===== rtl/ipv4_dotted_quad_parser.sv =====
// Top level of the IPv4 dotted-quad parser: input register, scan unit, result register.
// out_valid_o rises once the last character has passed the input register and the scan step into the result register.
// Throughput: one character per cycle; the input register stalls only when it holds
// a last character and the result register is full and stalled.
// Reset: rst_ni asynchronous active low, clears all scan state and both valid bits.
module ipv4_dotted_quad_parser #(
  parameter int unsigned MinLen = ipv4dq_pkg::DefMinLen,
  parameter int unsigned MaxLen = ipv4dq_pkg::DefMaxLen
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [7:0]  ch_i,
  input  logic        last_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [31:0] address_o,
  output logic [3:0]  status_o
);
  import ipv4dq_pkg::*;

  logic       in_vld_q;
  logic [7:0] ch_q;
  logic       last_q;
  logic       out_vld_q;
  logic       step;
  logic       res_fire;
  logic       out_free;
  result_t    res;
  result_t    res_q;

  assign out_free   = !out_vld_q || !out_stall_i;
  assign step       = in_vld_q && (!last_q || out_free);
  assign res_fire   = step && last_q;
  assign in_stall_o = in_vld_q && !step;

  ipv4dq_scan #(
    .MinLen(MinLen),
    .MaxLen(MaxLen)
  ) u_scan (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .step_i(step),
    .ch_i  (ch_q),
    .last_i(last_q),
    .res_o (res)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q  <= 1'b0;
      out_vld_q <= 1'b0;
    end else begin
      if (!in_stall_o) in_vld_q <= in_valid_i;
      if (res_fire) out_vld_q <= 1'b1;
      else if (!out_stall_i) out_vld_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (!in_stall_o && in_valid_i) begin
      ch_q   <= ch_i;
      last_q <= last_i;
    end
    if (res_fire) res_q <= res;
  end

  assign out_valid_o = out_vld_q;
  assign address_o   = res_q.address;
  assign status_o    = res_q.status;

endmodule

// ===== rtl/ipv4dq_scan.sv =====
// Per-character scan state and final address/status evaluation.
module ipv4dq_scan #(
  parameter int unsigned MinLen = ipv4dq_pkg::DefMinLen,
  parameter int unsigned MaxLen = ipv4dq_pkg::DefMaxLen
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                step_i,
  input  logic [7:0]          ch_i,
  input  logic                last_i,
  output ipv4dq_pkg::result_t res_o
);
  import ipv4dq_pkg::*;

  logic [9:0]  accum_q, accum_d;
  logic [2:0]  dcnt_q, dcnt_d;
  logic [2:0]  fidx_q, fidx_d;
  logic [7:0]  oct_q [4];
  logic [7:0]  oct_d [4];
  logic [4:0]  ccnt_q, ccnt_d;
  status_e     err_q, err_d;

  logic [13:0] mac;
  status_e     fin_err;
  status_e     cls;
  logic [7:0]  oct_f [4];

  assign mac = {4'd0, accum_q} * 14'd10 + {10'd0, ch_i[3:0] - ChZero[3:0]};

  always_comb begin
    accum_d = accum_q;
    dcnt_d  = dcnt_q;
    fidx_d  = fidx_q;
    err_d   = err_q;
    oct_d   = oct_q;
    ccnt_d  = (ccnt_q != 5'd31) ? ccnt_q + 5'd1 : ccnt_q;
    cls     = close_check(accum_q, dcnt_q);
    if (err_q == ST_OK) begin
      if (ch_i == ChDot) begin
        if (fidx_q > 3'd3) begin
          err_d = ST_MANY_FIELDS;
        end else begin
          err_d = cls;
          if (cls == ST_OK) oct_d[fidx_q[1:0]] = accum_q[7:0];
          accum_d = '0;
          dcnt_d  = '0;
          fidx_d  = fidx_q + 3'd1;
        end
      end else if (ch_i >= ChZero && ch_i <= ChNine) begin
        if (dcnt_q < 3'd3) accum_d = mac[9:0];
        if (dcnt_q < 3'd4) dcnt_d = dcnt_q + 3'd1;
      end else begin
        err_d = ST_BAD_CHAR;
      end
    end
  end

  always_comb begin
    fin_err = err_d;
    oct_f   = oct_d;
    if (err_d == ST_OK) begin
      if (fidx_d != 3'd3) begin
        fin_err = (fidx_d > 3'd3) ? ST_MANY_FIELDS : ST_FEW_FIELDS;
      end else begin
        fin_err = close_check(accum_d, dcnt_d);
        oct_f[3] = accum_d[7:0];
      end
    end
    if (ccnt_d < 5'(MinLen)) res_o.status = ST_SHORT;
    else if (ccnt_d > 5'(MaxLen)) res_o.status = ST_LONG;
    else res_o.status = fin_err;
    res_o.address = (res_o.status == ST_OK) ? {oct_f[3], oct_f[2], oct_f[1], oct_f[0]} : '0;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      accum_q <= '0;
      dcnt_q  <= '0;
      fidx_q  <= '0;
      ccnt_q  <= '0;
      err_q   <= ST_OK;
      for (int i = 0; i < 4; i++) oct_q[i] <= '0;
    end else if (step_i) begin
      if (last_i) begin
        accum_q <= '0;
        dcnt_q  <= '0;
        fidx_q  <= '0;
        ccnt_q  <= '0;
        err_q   <= ST_OK;
        for (int i = 0; i < 4; i++) oct_q[i] <= '0;
      end else begin
        accum_q <= accum_d;
        dcnt_q  <= dcnt_d;
        fidx_q  <= fidx_d;
        ccnt_q  <= ccnt_d;
        err_q   <= err_d;
        oct_q   <= oct_d;
      end
    end
  end

endmodule

// ===== rtl/ipv4dq_checker.sv =====
// Port-level assertions for the IPv4 dotted-quad parser, with bind.
module ipv4dq_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        in_valid_i,
  input logic        in_stall_o,
  input logic        out_valid_o,
  input logic        out_stall_i,
  input logic [31:0] address_o,
  input logic [3:0]  status_o
);
  import ipv4dq_pkg::*;

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(address_o) && $stable(status_o))
    else $error("stalled result transfer changed");

  a_err_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && status_o != ST_OK |-> address_o == 32'd0)
    else $error("address not zero on error status");

  a_status_rng: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> status_o <= ST_FEW_FIELDS)
    else $error("status code out of range");

  a_stall_cause: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> out_valid_o && out_stall_i)
    else $error("input stalled without output backpressure");

endmodule

bind ipv4_dotted_quad_parser ipv4dq_checker u_ipv4dq_checker (
  .clk_i      (clk_i),
  .rst_ni     (rst_ni),
  .in_valid_i (in_valid_i),
  .in_stall_o (in_stall_o),
  .out_valid_o(out_valid_o),
  .out_stall_i(out_stall_i),
  .address_o  (address_o),
  .status_o   (status_o)
);
